// ----- hw/rtl/dfd_pkg.sv -----
`default_nettype none

package dfd_pkg;

   // Event handed from the front classifier to the back assembler
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } dfd_event_type;

   // Result item kinds
   localparam logic ITEM_PAYLOAD = 1'b0;
   localparam logic ITEM_END     = 1'b1;

   // Frame status codes
   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_TOOLONG = 2'd2;

   // Register indexes
   localparam int         CSR_INDEX_W       = 2;
   localparam logic [1:0] CSR_START_PATTERN = 2'd0;
   localparam logic [1:0] CSR_END_PATTERN   = 2'd1;

   // Pattern registers and their reset values
   localparam int          PATTERN_W     = 24;
   localparam logic [23:0] START_DEFAULT = 24'h0FFFF0;
   localparam logic [23:0] END_DEFAULT   = 24'hF0000F;

   // Frame constants
   localparam logic [7:0] PAD_BYTE  = 8'h55;
   localparam int         LEN_SAT   = 256;
   localparam int         LEN_W     = 9;
   localparam int         LEAD_N    = 7;

   // Event queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

endpackage

`default_nettype wire

// ----- hw/rtl/dfd_front.sv -----
`default_nettype none

module dfd_front
   import dfd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_valid,
   input  wire logic [7:0]           byte_data,
   input  wire logic [PATTERN_W-1:0] start_pattern,
   input  wire logic [PATTERN_W-1:0] end_pattern,
   output logic                      evt_valid,
   output dfd_event_type             evt
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] win_ff [2];
   logic [7:0] win_in [2];
   logic [1:0] fill_ff, fill_in;
   logic [PATTERN_W-1:0] window;
   logic       start_hit, end_hit;

   // Three-byte view: two held bytes plus the incoming one
   assign window    = {win_ff[0], win_ff[1], byte_data};
   assign start_hit = (fill_ff == 2'd2) && (window == start_pattern);
   assign end_hit   = (fill_ff == 2'd2) && (window == end_pattern);

   // Classification and window update
   always_comb begin
      in_frame_in = in_frame_ff;
      win_in[0]   = win_ff[0];
      win_in[1]   = win_ff[1];
      fill_in     = fill_ff;
      evt_valid   = 1'b0;
      evt.is_end  = 1'b0;
      evt.data    = win_ff[0];
      if (byte_valid) begin
         if ((!in_frame_ff && start_hit) || (in_frame_ff && end_hit)) begin
            // delimiter found: window restarts empty
            in_frame_in = !in_frame_ff;
            fill_in     = 2'd0;
            evt_valid   = in_frame_ff;
            evt.is_end  = 1'b1;
         end else begin
            // held byte leaves the window as confirmed payload
            evt_valid = in_frame_ff && (fill_ff == 2'd2);
            if (fill_ff == 2'd0) begin
               win_in[0] = byte_data;
               fill_in   = 2'd1;
            end else if (fill_ff == 2'd1) begin
               win_in[1] = byte_data;
               fill_in   = 2'd2;
            end else begin
               win_in[0] = win_ff[1];
               win_in[1] = byte_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fill_ff     <= 2'd0;
         win_ff[0]   <= 8'd0;
         win_ff[1]   <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         fill_ff     <= fill_in;
         win_ff[0]   <= win_in[0];
         win_ff[1]   <= win_in[1];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dfd_queue.sv -----
`default_nettype none

module dfd_queue
   import dfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire dfd_event_type push_evt,
   output logic               full,
   input  wire logic          pop,
   output logic               valid,
   output dfd_event_type      pop_evt
);

   dfd_event_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                      do_push, do_pop;

   assign full    = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign pop_evt = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_evt;
      end
   end

   // Occupancy never exceeds the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("event queue occupancy out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/dfd_back.sv -----
`default_nettype none

module dfd_back
   import dfd_pkg::*;
#(
   parameter int MAX_PAYLOAD_LEN = 255
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          evt_valid,
   input  wire dfd_event_type evt,
   output logic               evt_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_pop,
   output logic               rsp_item_kind,
   output logic [7:0]         rsp_payload_byte,
   output logic [1:0]         rsp_frame_status,
   output logic [LEN_W-1:0]   rsp_frame_length,
   output logic [63:0]        rsp_single_frame_word
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD_LEN + 2);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      count_ext;
   logic [7:0]       lead_ff [LEAD_N];
   logic             lead_we;

   logic             valid_ff, valid_in;
   logic             kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic [1:0]       status_ff, status_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [63:0]      word_ff, word_in;

   logic [LEN_W-1:0] len_sat;
   logic [1:0]       status_calc;
   logic [63:0]      word_calc;

   assign count_ext = {{(32 - CNT_W){1'b0}}, count_ff};

   // Take a new event whenever the output register is free or draining
   assign evt_pop = evt_valid && (!valid_ff || rsp_pop);
   assign lead_we = evt_pop && !evt.is_end && (count_ext < 32'(LEAD_N));

   // Frame end summary
   always_comb begin
      len_sat = (count_ext >= 32'(LEN_SAT)) ? LEN_W'(LEN_SAT) : count_ext[LEN_W-1:0];
      if (count_ff == '0) begin
         status_calc = STATUS_EMPTY;
      end else if (count_ext > 32'(MAX_PAYLOAD_LEN)) begin
         status_calc = STATUS_TOOLONG;
      end else begin
         status_calc = STATUS_GOOD;
      end
      word_calc[63:56] = len_sat[7:0];
      for (int k = 1; k <= LEAD_N; k++) begin
         word_calc[(LEAD_N - k) * 8 +: 8] =
            (count_ext > 32'(k - 1)) ? lead_ff[k - 1] : PAD_BYTE;
      end
   end

   // Counter and output register update
   always_comb begin
      count_in  = count_ff;
      valid_in  = valid_ff && !rsp_pop;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      len_in    = len_ff;
      word_in   = word_ff;
      if (evt_pop) begin
         valid_in = 1'b1;
         if (evt.is_end) begin
            count_in  = '0;
            kind_in   = ITEM_END;
            byte_in   = 8'd0;
            status_in = status_calc;
            len_in    = len_sat;
            word_in   = word_calc;
         end else begin
            if (count_ext <= 32'(MAX_PAYLOAD_LEN)) begin
               count_in = count_ff + 1'b1;
            end
            kind_in   = ITEM_PAYLOAD;
            byte_in   = evt.data;
            status_in = STATUS_GOOD;
            len_in    = '0;
            word_in   = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      len_ff    <= len_in;
      word_ff   <= word_in;
      if (lead_we) begin
         lead_ff[count_ff[2:0]] <= evt.data;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_item_kind         = kind_ff;
   assign rsp_payload_byte      = byte_ff;
   assign rsp_frame_status      = status_ff;
   assign rsp_frame_length      = len_ff;
   assign rsp_single_frame_word = word_ff;

   // Empty status and zero length go together on a marker
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == ITEM_END) |->
         ((status_ff == STATUS_EMPTY) == (len_ff == '0)))
      else $error("empty status and length disagree");

   // Length byte of the single-frame word tracks the length
   a_word_len: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == ITEM_END) |->
         (word_ff[63:56] == len_ff[7:0] && len_ff <= LEN_W'(LEN_SAT)))
      else $error("single-frame word length byte mismatch");

   // A waiting result holds until it is popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_pop) |=> (valid_ff && $stable(word_ff) && $stable(byte_ff)))
      else $error("waiting result changed before pop");

endmodule

`default_nettype wire

// ----- hw/rtl/delimited_frame_deframer.sv -----
// A result reaches the rsp ports through the event queue, written at the edge that accepts the byte
// causing it, and then the back output register, written when the back takes that event.
// Throughput: 1 byte per cycle, set by the front three-byte window compare; the input
// stalls only while the 4-entry event queue is full behind a waiting result.
// Reset (synchronous): hunting for start, window, counters and queue cleared,
// pattern registers back to 0x0FFFF0 and 0xF0000F.
`default_nettype none

module delimited_frame_deframer
   import dfd_pkg::*;
#(
   parameter int MAX_PAYLOAD_LEN = 255
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [7:0]             req_data_byte,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic                        rsp_item_kind,
   output logic [7:0]                  rsp_payload_byte,
   output logic [1:0]                  rsp_frame_status,
   output logic [LEN_W-1:0]            rsp_frame_length,
   output logic [63:0]                 rsp_single_frame_word,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [PATTERN_W-1:0]   csr_wdata
);

   logic [PATTERN_W-1:0] start_ff, start_in;
   logic [PATTERN_W-1:0] end_ff, end_in;
   logic                 byte_valid;
   logic                 fe_valid;
   dfd_event_type        fe_evt;
   logic                 q_valid, q_pop;
   dfd_event_type        q_evt;
   logic                 rsp_valid;

   // Pattern registers; unknown indexes are dropped
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_PATTERN: start_in = csr_wdata;
            CSR_END_PATTERN:   end_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_DEFAULT;
         end_ff   <= END_DEFAULT;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   assign byte_valid = req_push && !req_full;
   assign rsp_empty  = !rsp_valid;

   dfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_valid    (byte_valid),
      .byte_data     (req_data_byte),
      .start_pattern (start_ff),
      .end_pattern   (end_ff),
      .evt_valid     (fe_valid),
      .evt           (fe_evt)
   );

   dfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fe_valid),
      .push_evt (fe_evt),
      .full     (req_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_evt  (q_evt)
   );

   dfd_back #(
      .MAX_PAYLOAD_LEN (MAX_PAYLOAD_LEN)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .evt_valid             (q_valid),
      .evt                   (q_evt),
      .evt_pop               (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_pop               (rsp_pop),
      .rsp_item_kind         (rsp_item_kind),
      .rsp_payload_byte      (rsp_payload_byte),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_frame_length      (rsp_frame_length),
      .rsp_single_frame_word (rsp_single_frame_word)
   );

endmodule

`default_nettype wire
